>>> hdl/mppe_receive_coherency_sync_macros.svh
// ---------------------------------------------------------------------------
// MPPE receive coherency sync: assertion macros
// Shared concurrent assertion forms for the coherency checker.
// ---------------------------------------------------------------------------
`ifndef MPPE_RECEIVE_COHERENCY_SYNC_MACROS_SVH
`define MPPE_RECEIVE_COHERENCY_SYNC_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MRCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrcs assertion failed: implication");

// Next-cycle implication with its own disable condition.
`define MRCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrcs assertion failed: next-cycle implication");

`endif

>>> hdl/mrcs_pkg.sv
// ---------------------------------------------------------------------------
// MPPE receive coherency sync: package
// Word types, status codes and constants shared by the checker modules.
// ---------------------------------------------------------------------------
package mrcs_pkg;

   localparam int COUNT_W   = 12;
   localparam int CTL_W     = 4;
   localparam int SCORE_W   = 16;
   localparam int STATUS_W  = 2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FATAL  = 2'd2;

   // flag nibble bit positions
   localparam int BIT_FLUSHED   = 3;
   localparam int BIT_ENCRYPTED = 0;

   localparam logic [COUNT_W-1:0] COUNT_RESET  = 12'hfff;
   localparam logic [7:0]         FLAG_LOW     = 8'hff;
   localparam logic [SCORE_W:0]   SCORE_STEP   = 17'd100;
   localparam logic [SCORE_W:0]   SCORE_STEP2  = 17'd200;
   localparam logic [SCORE_W-1:0] SCORE_MAX    = 16'hffff;
   localparam logic [SCORE_W-1:0] FATAL_LEVEL  = 16'd1600;

   typedef struct packed {
      logic [CTL_W-1:0]   control_bits;
      logic [COUNT_W-1:0] coherency_count;
      logic               too_short;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  rekey_count;
      logic                loss_detected;
   } rsp_word_type;

endpackage

>>> hdl/mrcs_ifs.sv
// ---------------------------------------------------------------------------
// MPPE receive coherency sync: channel interfaces
// Valid/ready channels for frame headers, results and the mode register.
// ---------------------------------------------------------------------------
interface mrcs_req_if;
   logic                           valid;
   logic                           ready;
   logic [mrcs_pkg::CTL_W-1:0]     control_bits;
   logic [mrcs_pkg::COUNT_W-1:0]   coherency_count;
   logic                           too_short;

   modport source (output valid, output control_bits, output coherency_count,
                   output too_short, input ready);
   modport sink   (input valid, input control_bits, input coherency_count,
                   input too_short, output ready);
endinterface

interface mrcs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mrcs_pkg::STATUS_W-1:0]  status;
   logic [mrcs_pkg::COUNT_W-1:0]   rekey_count;
   logic                           loss_detected;

   modport source (output valid, output status, output rekey_count,
                   output loss_detected, input ready);
   modport sink   (input valid, input status, input rekey_count,
                   input loss_detected, output ready);
endinterface

interface mrcs_csr_if;
   logic valid;
   logic ready;
   logic stateful_mode;

   modport source (output valid, output stateful_mode, input ready);
   modport sink   (input valid, input stateful_mode, output ready);
endinterface

>>> hdl/mppe_receive_coherency_sync.sv
// ---------------------------------------------------------------------------
// MPPE receive coherency sync: top level
// Receive-side coherency count checker for MPPE frame headers.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one frame header word: flag nibble, 12-bit coherency
//   count and a short-frame flag. rsp_chan returns one word per header:
//   status (accept, drop, fatal), the number of key updates to run before
//   decrypting, and a loss flag. csr_chan writes the stateful-mode bit;
//   write it only while no header is in flight.
//   A taken header is held in the input register until its result word
//   is captured in the result register, which drives rsp_chan.
//   Throughput: one header per cycle while rsp_chan.ready is high; the
//   check and state update are combinational between the two registers.
//   Reset: stateless mode, expected count 4095, not discarding, error
//   score 0; both channels empty.
//   Receiver stall: the result register holds; the input register still
//   takes one more header, after which req_chan.ready drops until the
//   result word is taken.
// ---------------------------------------------------------------------------
`include "mppe_receive_coherency_sync_macros.svh"

module mppe_receive_coherency_sync (
   input  logic       clock,
   input  logic       reset,
   mrcs_req_if.sink   req_chan,
   mrcs_rsp_if.source rsp_chan,
   mrcs_csr_if.sink   csr_chan
);

   logic                   word_valid;
   mrcs_pkg::req_word_type word;
   mrcs_pkg::rsp_word_type result;
   logic                   can_load;
   logic                   advance;

   // move a held header into the result register when there is room
   assign advance = word_valid && can_load;

   mrcs_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   mrcs_core u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .advance  (advance),
      .word     (word),
      .result   (result)
   );

   mrcs_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .rsp_chan (rsp_chan),
      .load     (advance),
      .result   (result),
      .can_load (can_load)
   );

   // a rejected frame never asks for key updates
   `MRCS_ASSERT_IMPLY(a_no_rekey_on_reject, clock, reset, rsp_chan.valid && (rsp_chan.status != mrcs_pkg::STATUS_ACCEPT), rsp_chan.rekey_count == '0)
   // loss is only ever reported with a dropped frame
   `MRCS_ASSERT_IMPLY(a_loss_means_drop, clock, reset, rsp_chan.valid && rsp_chan.loss_detected, rsp_chan.status == mrcs_pkg::STATUS_DROP)
   // no result word straight after reset
   `MRCS_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_chan.valid)
   // no result appears without a header having been taken
   `MRCS_ASSERT_NEXT(a_result_needs_header, clock, reset, !rsp_chan.valid && !word_valid, !rsp_chan.valid)

endmodule

>>> hdl/mrcs_in_reg.sv
// ---------------------------------------------------------------------------
// MPPE receive coherency sync: input register
// Captures one header word and holds it until the check stage takes it.
// ---------------------------------------------------------------------------
module mrcs_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   mrcs_req_if.sink               req_chan,
   input  logic                   advance,
   output logic                   word_valid,
   output mrcs_pkg::req_word_type word
);

   logic                   valid_ff;
   logic                   valid_in;
   mrcs_pkg::req_word_type word_ff;
   logic                   take;

   // accept while empty or while the held word moves on
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the payload until replaced
   always_ff @(posedge clock) begin
      if (take) begin
         word_ff.control_bits    <= req_chan.control_bits;
         word_ff.coherency_count <= req_chan.coherency_count;
         word_ff.too_short       <= req_chan.too_short;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

>>> hdl/mrcs_core.sv
// ---------------------------------------------------------------------------
// MPPE receive coherency sync: check core
// Holds the mode register and coherency state, checks one header word and
// forms its result word.
// ---------------------------------------------------------------------------
module mrcs_core (
   input  logic                   clock,
   input  logic                   reset,
   mrcs_csr_if.sink               csr_chan,
   input  logic                   advance,
   input  mrcs_pkg::req_word_type word,
   output mrcs_pkg::rsp_word_type result
);

   logic                                stateful_mode_ff;
   logic [mrcs_pkg::COUNT_W-1:0]        expected_ff;
   logic [mrcs_pkg::COUNT_W-1:0]        expected_in;
   logic                                discarding_ff;
   logic                                discarding_in;
   logic [mrcs_pkg::SCORE_W-1:0]        score_ff;
   logic [mrcs_pkg::SCORE_W-1:0]        score_in;

   logic                                flushed;
   logic                                fault_enc;
   logic                                fault_mode;
   logic [mrcs_pkg::SCORE_W:0]          score_sum;
   logic [mrcs_pkg::SCORE_W-1:0]        score_sat;
   logic [mrcs_pkg::COUNT_W-1:0]        expected_next;
   logic [3:0]                          nibble_gap;

   assign csr_chan.ready = 1'b1;

   // header faults
   assign flushed    = word.control_bits[mrcs_pkg::BIT_FLUSHED];
   assign fault_enc  = !word.control_bits[mrcs_pkg::BIT_ENCRYPTED];
   assign fault_mode = !flushed && (!stateful_mode_ff ||
                       (word.coherency_count[7:0] == mrcs_pkg::FLAG_LOW));

   // saturating score after one or two faults
   assign score_sum = {1'b0, score_ff} +
                      ((fault_enc && fault_mode) ? mrcs_pkg::SCORE_STEP2
                                                 : mrcs_pkg::SCORE_STEP);
   assign score_sat = score_sum[mrcs_pkg::SCORE_W] ? mrcs_pkg::SCORE_MAX
                                                   : score_sum[mrcs_pkg::SCORE_W-1:0];

   assign expected_next = expected_ff + 12'd1;
   assign nibble_gap    = word.coherency_count[11:8] - expected_ff[11:8];

   // decide result and next state
   always_comb begin
      expected_in          = expected_ff;
      discarding_in        = discarding_ff;
      score_in             = score_ff;
      result.status        = mrcs_pkg::STATUS_ACCEPT;
      result.rekey_count   = '0;
      result.loss_detected = 1'b0;
      if (word.too_short) begin
         result.status = mrcs_pkg::STATUS_DROP;
      end else if (fault_enc || fault_mode) begin
         score_in      = score_sat;
         result.status = (score_sat < mrcs_pkg::FATAL_LEVEL) ? mrcs_pkg::STATUS_DROP
                                                             : mrcs_pkg::STATUS_FATAL;
      end else if (!stateful_mode_ff) begin
         result.rekey_count = word.coherency_count - expected_ff;
         expected_in        = word.coherency_count;
         score_in           = score_ff >> 1;
      end else if (!discarding_ff) begin
         expected_in = expected_next;
         if (word.coherency_count != expected_next) begin
            discarding_in        = 1'b1;
            result.status        = mrcs_pkg::STATUS_DROP;
            result.loss_detected = 1'b1;
         end else begin
            result.rekey_count = {11'd0, flushed};
            score_in           = score_ff >> 1;
         end
      end else if (!flushed) begin
         result.status = mrcs_pkg::STATUS_DROP;
      end else begin
         result.rekey_count = {8'd0, nibble_gap} + 12'd1;
         discarding_in      = 1'b0;
         expected_in        = word.coherency_count;
         score_in           = score_ff >> 1;
      end
   end

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         stateful_mode_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         stateful_mode_ff <= csr_chan.stateful_mode;
      end
   end

   // advance the coherency state once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= mrcs_pkg::COUNT_RESET;
         discarding_ff <= 1'b0;
         score_ff      <= '0;
      end else if (advance) begin
         expected_ff   <= expected_in;
         discarding_ff <= discarding_in;
         score_ff      <= score_in;
      end
   end

endmodule

>>> hdl/mrcs_out_reg.sv
// ---------------------------------------------------------------------------
// MPPE receive coherency sync: result register
// Holds one result word until the receiver takes it.
// ---------------------------------------------------------------------------
module mrcs_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   mrcs_rsp_if.source             rsp_chan,
   input  logic                   load,
   input  mrcs_pkg::rsp_word_type result,
   output logic                   can_load
);

   logic                   valid_ff;
   logic                   valid_in;
   mrcs_pkg::rsp_word_type word_ff;

   // room when empty or when the held word leaves this cycle
   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.status        = word_ff.status;
   assign rsp_chan.rekey_count   = word_ff.rekey_count;
   assign rsp_chan.loss_detected = word_ff.loss_detected;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MPPE receive coherency sync: testbench
// Drives frame header words into the checker, predicts each result word
// from an in-bench model of the coherency state and compares the two. A
// short table of hand-picked headers comes first, then random phases in
// both modes, including a fault storm that drives the error score into
// saturation. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
   import mrcs_pkg::*;

   // receiver stall styles
   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_CHOKED} rx_style_type;

   // one row of the directed table
   typedef struct packed {
      logic                mode;
      logic [CTL_W-1:0]    ctl;
      logic [COUNT_W-1:0]  cnt;
      logic                short_frame;
      logic                known;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  rekeys;
      logic                loss;
   } dir_row_type;

   localparam int DIR_ROWS_N = 24;
   localparam dir_row_type DIR_ROWS [0:DIR_ROWS_N-1] = '{
      // stateless, straight after reset
      '{1'b0, 4'b1001, 12'h000, 1'b0, 1'b1, STATUS_ACCEPT, 12'd1,   1'b0},
      '{1'b0, 4'b1001, 12'h000, 1'b0, 1'b1, STATUS_ACCEPT, 12'd0,   1'b0},
      '{1'b0, 4'b1001, 12'hfff, 1'b0, 1'b1, STATUS_ACCEPT, 12'hfff, 1'b0},
      '{1'b0, 4'b1111, 12'hfff, 1'b1, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      // header faults, score climbs to fatal
      '{1'b0, 4'b0000, 12'h000, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b0, 4'b1000, 12'h000, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b0, 4'b0001, 12'h000, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b0, 4'b0110, 12'h555, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b0, 4'b0110, 12'haaa, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b0, 4'b0110, 12'h000, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b0, 4'b0110, 12'hfff, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b0, 4'b0110, 12'h800, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b0, 4'b0110, 12'h7ff, 1'b0, 1'b1, STATUS_FATAL,  12'd0,   1'b0},
      '{1'b0, 4'b1111, 12'h123, 1'b0, 1'b1, STATUS_ACCEPT, 12'h124, 1'b0},
      // stateful: in step, flag frame fault, loss, discard, resync
      '{1'b1, 4'b0001, 12'h124, 1'b0, 1'b0, STATUS_ACCEPT, 12'd0,   1'b0},
      '{1'b1, 4'b1001, 12'h125, 1'b0, 1'b0, STATUS_ACCEPT, 12'd0,   1'b0},
      '{1'b1, 4'b0001, 12'h1ff, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b1, 4'b0001, 12'h127, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b1},
      '{1'b1, 4'b0001, 12'h200, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b1, 4'b1001, 12'h0ff, 1'b0, 1'b1, STATUS_ACCEPT, 12'd16,  1'b0},
      '{1'b1, 4'b1001, 12'h100, 1'b0, 1'b0, STATUS_ACCEPT, 12'd0,   1'b0},
      '{1'b1, 4'b1000, 12'h101, 1'b0, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b1, 4'b1001, 12'h101, 1'b1, 1'b1, STATUS_DROP,   12'd0,   1'b0},
      '{1'b1, 4'b1001, 12'h101, 1'b0, 1'b0, STATUS_ACCEPT, 12'd0,   1'b0}
   };

   // random phases: mode, header count, fault storm
   localparam int PHASES_N = 6;
   localparam logic PHASE_MODE  [0:PHASES_N-1] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
   localparam int   PHASE_ITEMS [0:PHASES_N-1] = '{120, 200, 340, 60, 250, 60};
   localparam logic PHASE_STORM [0:PHASES_N-1] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

   logic clock;
   logic reset;

   mrcs_req_if req_bus ();
   mrcs_rsp_if rsp_bus ();
   mrcs_csr_if csr_bus ();

   mppe_receive_coherency_sync u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // coherency state as the receiver should hold it
   logic               rx_stateful;
   logic [COUNT_W-1:0] rx_expected;
   logic               rx_discarding;
   logic [SCORE_W-1:0] rx_score;

   rsp_word_type pending_results [$];
   int           mismatches;
   int           burst_left;
   rx_style_type rx_style;
   int           rx_style_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("mppe_receive_coherency_sync verification failed");
      $finish;
   end

   // Work out the result word for one header and advance the coherency state.
   function automatic rsp_word_type predict_header(input req_word_type h);
      rsp_word_type r;
      logic         flushed;
      int           faults;
      int           sum;
      r       = '0;
      r.status = STATUS_ACCEPT;
      flushed = h.control_bits[BIT_FLUSHED];
      faults  = 0;
      if (h.too_short) begin
         r.status = STATUS_DROP;
         return r;
      end
      if (!h.control_bits[BIT_ENCRYPTED]) faults++;
      if (!rx_stateful && !flushed) faults++;
      if (rx_stateful && h.coherency_count[7:0] == FLAG_LOW && !flushed) faults++;
      if (faults != 0) begin
         sum      = int'(rx_score) + faults * int'(SCORE_STEP);
         rx_score = (sum > int'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(sum);
         r.status = (rx_score < FATAL_LEVEL) ? STATUS_DROP : STATUS_FATAL;
         return r;
      end
      if (!rx_stateful) begin
         r.rekey_count = h.coherency_count - rx_expected;
         rx_expected   = h.coherency_count;
      end else if (!rx_discarding) begin
         rx_expected = rx_expected + 12'd1;
         if (h.coherency_count != rx_expected) begin
            rx_discarding   = 1'b1;
            r.status        = STATUS_DROP;
            r.loss_detected = 1'b1;
            return r;
         end
         r.rekey_count = {11'd0, flushed};
      end else begin
         if (!flushed) begin
            r.status = STATUS_DROP;
            return r;
         end
         r.rekey_count = {8'd0, 4'(h.coherency_count[11:8] - rx_expected[11:8])} + 12'd1;
         rx_discarding = 1'b0;
         rx_expected   = h.coherency_count;
      end
      rx_score = rx_score >> 1;
      return r;
   endfunction

   // Pick a random header, mostly one that keeps the receiver moving.
   function automatic req_word_type pick_header(input logic storm);
      req_word_type h;
      int unsigned  roll;
      roll              = $urandom_range(0, 99);
      h.control_bits    = CTL_W'($urandom);
      h.coherency_count = COUNT_W'($urandom);
      h.too_short       = 1'b0;
      // fault storm: neither encrypted nor flushed
      if (storm) begin
         h.control_bits[BIT_ENCRYPTED] = 1'b0;
         h.control_bits[BIT_FLUSHED]   = 1'b0;
         return h;
      end
      if (roll < 4) begin
         h.too_short = 1'b1;
         return h;
      end
      if (roll < 12) return h;
      h.control_bits[BIT_ENCRYPTED] = 1'b1;
      if (!rx_stateful) begin
         h.control_bits[BIT_FLUSHED] = 1'b1;
         if (roll < 80) h.coherency_count = rx_expected + COUNT_W'($urandom_range(0, 3));
      end else if (!rx_discarding) begin
         // mostly in step, now and then a gap
         if (roll < 88) h.coherency_count = rx_expected + 12'd1;
         if (h.coherency_count[7:0] == FLAG_LOW)
            h.control_bits[BIT_FLUSHED] = ($urandom_range(0, 7) != 0);
         else
            h.control_bits[BIT_FLUSHED] = ($urandom_range(0, 3) == 0);
      end else begin
         // resync close below a flag frame half the time
         h.control_bits[BIT_FLUSHED] = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 1) != 0)
            h.coherency_count[7:0] = 8'hf0 + 8'($urandom_range(0, 15));
      end
      return h;
   endfunction

   // Offer one header word, idling between bursts, and queue its result.
   task automatic send_header(input req_word_type h, input logic known,
                              input rsp_word_type typed);
      rsp_word_type calc;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      calc = predict_header(h);
      pending_results.push_back(known ? typed : calc);
      req_bus.valid           <= 1'b1;
      req_bus.control_bits    <= h.control_bits;
      req_bus.coherency_count <= h.coherency_count;
      req_bus.too_short       <= h.too_short;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   // Let the block go idle, then write the mode register.
   task automatic write_mode(input logic m);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_bus.valid         <= 1'b1;
      csr_bus.stateful_mode <= m;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      rx_stateful = m;
   endtask

   // Check each accepted result word, then choose the next ready level.
   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word, status %0d rekeys %0d loss %0d",
                     $time, rsp_bus.status, rsp_bus.rekey_count, rsp_bus.loss_detected);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.rekey_count !== want.rekey_count) begin
               $display("%0t: rekey_count mismatch, expected %0d, actual %0d",
                        $time, want.rekey_count, rsp_bus.rekey_count);
               mismatches++;
            end
            if (rsp_bus.loss_detected !== want.loss_detected) begin
               $display("%0t: loss_detected mismatch, expected %0d, actual %0d",
                        $time, want.loss_detected, rsp_bus.loss_detected);
               mismatches++;
            end
         end
      end
      if (rx_style_left <= 0) begin
         rx_style      = rx_style_type'($urandom_range(0, 3));
         rx_style_left = $urandom_range(16, 96);
      end
      rx_style_left--;
      case (rx_style)
         RX_OPEN:   rsp_bus.ready <= 1'b1;
         RX_LIGHT:  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY:  rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_bus.ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   initial begin : stimulus
      req_word_type h;
      rsp_word_type typed;
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.control_bits    = '0;
      req_bus.coherency_count = '0;
      req_bus.too_short       = 1'b0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.stateful_mode   = 1'b0;
      rx_stateful             = 1'b0;
      rx_expected             = COUNT_RESET;
      rx_discarding           = 1'b0;
      rx_score                = '0;
      mismatches              = 0;
      burst_left              = 0;
      rx_style                = RX_OPEN;
      rx_style_left           = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table; change mode only when the row asks
      for (int i = 0; i < DIR_ROWS_N; i++) begin
         if (DIR_ROWS[i].mode != rx_stateful) write_mode(DIR_ROWS[i].mode);
         h.control_bits      = DIR_ROWS[i].ctl;
         h.coherency_count   = DIR_ROWS[i].cnt;
         h.too_short         = DIR_ROWS[i].short_frame;
         typed.status        = DIR_ROWS[i].status;
         typed.rekey_count   = DIR_ROWS[i].rekeys;
         typed.loss_detected = DIR_ROWS[i].loss;
         send_header(h, DIR_ROWS[i].known, typed);
      end

      // random phases, each opened by a mode write
      for (int p = 0; p < PHASES_N; p++) begin
         write_mode(PHASE_MODE[p]);
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            h = pick_header(PHASE_STORM[p]);
            send_header(h, 1'b0, '0);
         end
      end

      // drain and let the pipeline settle
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("mppe_receive_coherency_sync verification clean");
      else
         $display("mppe_receive_coherency_sync verification failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/mrcs_pkg.sv
hdl/mrcs_ifs.sv
hdl/mrcs_in_reg.sv
hdl/mrcs_core.sv
hdl/mrcs_out_reg.sv
hdl/mppe_receive_coherency_sync.sv
tb/sv/tb_top.sv
